// ===== sv/rcc_pkg.sv =====
// Shared types, constants and helpers for the raster co-occurrence counter.
package rcc_pkg;

    // Raster and class dimensions
    localparam int MAX_COLUMNS  = 64;
    localparam int MAX_ROWS     = 64;
    localparam int NUM_CLASSES  = 16;
    localparam int RASTER_DEPTH = MAX_COLUMNS * MAX_ROWS;

    localparam int ADDR_W   = $clog2(RASTER_DEPTH);
    localparam int COL_W    = $clog2(MAX_COLUMNS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int DIM_W    = 7;
    localparam int CLASS_W  = 4;
    localparam int MASK_W   = 16;
    localparam int COUNT_W  = 16;
    localparam int CELL_W   = 2 * CLASS_W;
    localparam int CELLS    = NUM_CLASSES * NUM_CLASSES;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Action codes
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_RUN  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONNECT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_MSK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGH_MSK = 3'd4;

    // Neighbour offsets: rook moves first, then the diagonals
    localparam logic signed [1:0] STEP_COL [8] = '{2'sd0, -2'sd1, 2'sd1, 2'sd0,
                                                   -2'sd1, 2'sd1, -2'sd1, 2'sd1};
    localparam logic signed [1:0] STEP_ROW [8] = '{-2'sd1, 2'sd0, 2'sd0, 2'sd1,
                                                   -2'sd1, -2'sd1, 2'sd1, 2'sd1};

    typedef struct packed {
        logic [1:0]         action;
        logic [CLASS_W-1:0] focal_value;
        logic [CLASS_W-1:0] neighbour_value;
        logic [CLASS_W-1:0] read_focal_class;
        logic [CLASS_W-1:0] read_neighbour_class;
    } rcc_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] pair_count;
        logic               status;
    } rcc_out_t;

    // Zero reads as one, anything above the maximum as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] max_v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > max_v) begin
            r = max_v;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic class_enabled(input logic [CLASS_W-1:0] cls,
                                           input logic [MASK_W-1:0] mask);
        return (32'(cls) < NUM_CLASSES) && mask[cls];
    endfunction

endpackage

// ===== sv/raster_cooccurrence_counter.sv =====
// Top level of the raster co-occurrence counter: loader, run sequencer and count memory.

// Loads and unused actions finish in ST_IDLE and a read of one count passes through
// ST_READ; each gives a registered result beat when it finishes. A run walks the
// loaded raster in column-major order through a sequencer that shares one
// read-modify-write path into the count memory: every focal pixel passes through
// ST_FRD and ST_FCHK, and every neighbour of an enabled focal pixel through ST_NRD,
// then ST_NCHK when it lies inside the raster, then ST_CUPD when its class is
// enabled and it is counted. The count matrix is cleared at the start of a run
// through per-entry valid flags, so there is no clearing pass. The input stays busy
// through a run, and while a result beat waits on a stalled output.
module raster_cooccurrence_counter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rcc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  rcc_pkg::rcc_in_t               s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output rcc_pkg::rcc_out_t              m_data
);
    import rcc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FRD,
        ST_FCHK,
        ST_NRD,
        ST_NCHK,
        ST_CUPD
    } state_t;

    // Configuration registers
    logic [DIM_W-1:0]  columns_reg;
    logic [DIM_W-1:0]  rows_reg;
    logic              connect_reg;
    logic [MASK_W-1:0] focal_mask_reg;
    logic [MASK_W-1:0] neigh_mask_reg;

    // Sequencer state
    state_t             state_reg;
    logic [ADDR_W:0]    load_pos_reg;
    logic [ADDR_W-1:0]  pix_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [2:0]         nb_reg;
    logic [CLASS_W-1:0] fx_reg;
    logic [CELL_W-1:0]  cell_reg;
    logic [CELLS-1:0]   cell_valid_reg;
    logic               m_valid_reg;
    rcc_out_t           m_data_reg;

    // Memories
    logic [CLASS_W-1:0] focal_mem [RASTER_DEPTH];
    logic [CLASS_W-1:0] neigh_mem [RASTER_DEPTH];
    logic [COUNT_W-1:0] count_mem [CELLS];
    logic [CLASS_W-1:0] f_rd_data;
    logic [CLASS_W-1:0] n_rd_data;
    logic [COUNT_W-1:0] c_rd_data;

    // Derived control
    logic [DIM_W-1:0]  ncols;
    logic [DIM_W-1:0]  nrows;
    logic [ADDR_W:0]   limit;
    logic              room;
    logic              in_beat;
    logic              load_we;
    logic [ADDR_W-1:0] n_addr;
    logic [ADDR_W-1:0] col_off;
    logic signed [COL_W+1:0] nb_col;
    logic signed [ROW_W+1:0] nb_row;
    logic              nb_in_bounds;
    logic              nb_last;
    logic              last_row;
    logic              last_col;
    logic              nb_end;
    logic              pix_end;
    logic [CELL_W-1:0] c_rd_addr;
    logic [COUNT_W-1:0] cell_value;
    logic [COUNT_W-1:0] cell_inc;

    // Clamp dimensions and size the raster
    assign ncols   = clamp_dim(columns_reg, DIM_W'(MAX_COLUMNS));
    assign nrows   = clamp_dim(rows_reg, DIM_W'(MAX_ROWS));
    assign limit   = (ADDR_W+1)'(ncols) * (ADDR_W+1)'(nrows);
    assign room    = load_pos_reg < limit;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_beat = s_valid && s_ready;
    assign load_we = in_beat && (s_data.action == ACT_LOAD) && room;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Locate the current neighbour
    always_comb begin
        nb_col = signed'({2'b00, col_reg}) + (COL_W+2)'(STEP_COL[nb_reg]);
        nb_row = signed'({2'b00, row_reg}) + (ROW_W+2)'(STEP_ROW[nb_reg]);
        nb_in_bounds = !nb_col[COL_W+1] && !nb_row[ROW_W+1]
                       && (nb_col < signed'((COL_W+2)'(ncols)))
                       && (nb_row < signed'((ROW_W+2)'(nrows)));
        if (STEP_COL[nb_reg] < 0) begin
            col_off = ADDR_W'(0) - ADDR_W'(nrows);
        end else if (STEP_COL[nb_reg] > 0) begin
            col_off = ADDR_W'(nrows);
        end else begin
            col_off = '0;
        end
        n_addr = pix_reg + col_off + ADDR_W'(STEP_ROW[nb_reg]);
    end

    // Decide where the walk goes next
    always_comb begin
        nb_last  = connect_reg ? (nb_reg == 3'd7) : (nb_reg == 3'd3);
        last_row = ({1'b0, row_reg} == (nrows - DIM_W'(1)));
        last_col = ({1'b0, col_reg} == (ncols - DIM_W'(1)));
        case (state_reg)
            ST_NRD:  nb_end = !nb_in_bounds;
            ST_NCHK: nb_end = !class_enabled(n_rd_data, neigh_mask_reg);
            ST_CUPD: nb_end = 1'b1;
            default: nb_end = 1'b0;
        endcase
        pix_end = ((state_reg == ST_FCHK) && !class_enabled(f_rd_data, focal_mask_reg))
                  || (nb_end && nb_last);
    end

    // Count memory addressing and saturating increment
    always_comb begin
        c_rd_addr  = (state_reg == ST_IDLE)
                     ? {s_data.read_focal_class, s_data.read_neighbour_class}
                     : {fx_reg, n_rd_data};
        cell_value = cell_valid_reg[cell_reg] ? c_rd_data : '0;
        cell_inc   = (cell_value == '1) ? cell_value : cell_value + COUNT_W'(1);
    end

    // Raster memories: write on load, read every cycle
    always_ff @(posedge aclk) begin
        if (load_we) begin
            focal_mem[load_pos_reg[ADDR_W-1:0]] <= s_data.focal_value;
            neigh_mem[load_pos_reg[ADDR_W-1:0]] <= s_data.neighbour_value;
        end
        f_rd_data <= focal_mem[pix_reg];
        n_rd_data <= neigh_mem[n_addr];
    end

    // Count memory: write back the incremented entry
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CUPD) begin
            count_mem[cell_reg] <= cell_inc;
        end
        c_rd_data <= count_mem[c_rd_addr];
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg    <= DIM_W'(MAX_COLUMNS);
            rows_reg       <= DIM_W'(MAX_ROWS);
            connect_reg    <= 1'b0;
            focal_mask_reg <= '1;
            neigh_mask_reg <= '1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_COLUMNS:   columns_reg    <= cfg_wdata[DIM_W-1:0];
                REG_ROWS:      rows_reg       <= cfg_wdata[DIM_W-1:0];
                REG_CONNECT:   connect_reg    <= cfg_wdata[0];
                REG_FOCAL_MSK: focal_mask_reg <= cfg_wdata[MASK_W-1:0];
                REG_NEIGH_MSK: neigh_mask_reg <= cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            load_pos_reg   <= '0;
            pix_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            nb_reg         <= '0;
            cell_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // drop the beat once taken
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        unique case (s_data.action)
                            ACT_LOAD: begin
                                if (room) begin
                                    load_pos_reg <= load_pos_reg + (ADDR_W+1)'(1);
                                end
                                m_valid_reg           <= 1'b1;
                                m_data_reg.pair_count <= '0;
                                m_data_reg.status     <= !room;
                            end
                            ACT_RUN: begin
                                load_pos_reg   <= '0;
                                pix_reg        <= '0;
                                col_reg        <= '0;
                                row_reg        <= '0;
                                cell_valid_reg <= '0;
                                state_reg      <= ST_FRD;
                            end
                            ACT_READ: begin
                                cell_reg  <= {s_data.read_focal_class,
                                              s_data.read_neighbour_class};
                                state_reg <= ST_READ;
                            end
                            default: begin
                                m_valid_reg           <= 1'b1;
                                m_data_reg.pair_count <= '0;
                                m_data_reg.status     <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    m_valid_reg           <= 1'b1;
                    m_data_reg.pair_count <= cell_value;
                    m_data_reg.status     <= 1'b0;
                    state_reg             <= ST_IDLE;
                end
                ST_FRD: begin
                    state_reg <= ST_FCHK;
                end
                ST_FCHK: begin
                    fx_reg    <= f_rd_data;
                    nb_reg    <= '0;
                    state_reg <= ST_NRD;
                end
                ST_NRD: begin
                    state_reg <= ST_NCHK;
                end
                ST_NCHK: begin
                    cell_reg  <= {fx_reg, n_rd_data};
                    state_reg <= ST_CUPD;
                end
                ST_CUPD: begin
                    cell_valid_reg[cell_reg] <= 1'b1;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // advance to the next neighbour or pixel, or finish the run
            if (pix_end) begin
                if (last_row && last_col) begin
                    m_valid_reg           <= 1'b1;
                    m_data_reg.pair_count <= '0;
                    m_data_reg.status     <= 1'b0;
                    state_reg             <= ST_IDLE;
                end else begin
                    pix_reg   <= pix_reg + ADDR_W'(1);
                    state_reg <= ST_FRD;
                    if (last_row) begin
                        row_reg <= '0;
                        col_reg <= col_reg + COL_W'(1);
                    end else begin
                        row_reg <= row_reg + ROW_W'(1);
                    end
                end
            end else if (nb_end) begin
                nb_reg    <= nb_reg + 3'd1;
                state_reg <= ST_NRD;
            end
        end
    end

endmodule
